@@ design/itp_pkg.sv @@
// shared types and constants for the integer text parser
`timescale 1ns / 1ps

package itp_pkg;

  localparam int VALUE_BITS_DEF  = 64;
  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int RADIX_W   = 6;
  localparam int CH_W      = 8;
  localparam int VALUE_W   = 64;
  localparam int OFFSET_W  = 16;
  localparam int M_TDATA_W = VALUE_W + OFFSET_W;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7a;
  localparam logic [CH_W-1:0] LETTER_BASE = 8'd10;

  typedef enum logic [0:0] {
    CFG_RADIX       = 1'b0,
    CFG_SIGNED_MODE = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_PLUS  = 2'd2,
    KIND_MINUS = 2'd3
  } kind_t;

  typedef struct packed {
    logic                start;
    kind_t               kind;
    logic [RADIX_W-1:0]  digit;
  } item_t;

endpackage

@@ design/itp_front.sv @@
// front end: takes input bytes and classifies them as digit, sign or terminator
`timescale 1ns / 1ps

module itp_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [itp_pkg::CH_W-1:0]     s_tdata,   // [7:0] ch
  input  logic                         s_tuser,   // [0] start_req
  input  logic [itp_pkg::RADIX_W-1:0]  radix,
  input  logic                         signed_mode,
  input  logic                         q_full,
  output logic                         q_push,
  output itp_pkg::item_t               q_item
);

  logic [itp_pkg::CH_W-1:0] dval;
  logic                     is_alnum;

  always_comb begin
    dval     = '0;
    is_alnum = 1'b1;
    if (s_tdata >= itp_pkg::CH_ZERO && s_tdata <= itp_pkg::CH_NINE) begin
      dval = s_tdata - itp_pkg::CH_ZERO;
    end else if (s_tdata >= itp_pkg::CH_LOWER_A && s_tdata <= itp_pkg::CH_LOWER_Z) begin
      dval = s_tdata - itp_pkg::CH_LOWER_A + itp_pkg::LETTER_BASE;
    end else if (s_tdata >= itp_pkg::CH_UPPER_A && s_tdata <= itp_pkg::CH_UPPER_Z) begin
      dval = s_tdata - itp_pkg::CH_UPPER_A + itp_pkg::LETTER_BASE;
    end else begin
      is_alnum = 1'b0;
    end
  end

  always_comb begin
    q_item.start = s_tuser;
    q_item.digit = dval[itp_pkg::RADIX_W-1:0];
    if (is_alnum && dval < {2'b00, radix}) begin
      q_item.kind = itp_pkg::KIND_DIGIT;
    end else if (s_tdata == itp_pkg::CH_PLUS) begin
      q_item.kind = itp_pkg::KIND_PLUS;
    end else if (s_tdata == itp_pkg::CH_MINUS && signed_mode) begin
      // minus only counts as a sign in signed mode
      q_item.kind = itp_pkg::KIND_MINUS;
    end else begin
      q_item.kind = itp_pkg::KIND_OTHER;
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

endmodule

@@ design/itp_queue.sv @@
// short queue of classified bytes between front and back end
`timescale 1ns / 1ps

module itp_queue #(
  parameter int DEPTH = itp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itp_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output itp_pkg::item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  itp_pkg::item_t     mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/itp_back.sv @@
// back end: parse state, multiply-add accumulator and result register
`timescale 1ns / 1ps

module itp_back #(
  parameter int VALUE_BITS  = itp_pkg::VALUE_BITS_DEF,
  parameter int OFFSET_BITS = itp_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [itp_pkg::RADIX_W-1:0]     radix,
  input  logic                            q_valid,
  input  itp_pkg::item_t                  q_item,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [itp_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                            m_tuser
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [VALUE_BITS-1:0]  acc, acc_next;
  logic [OFFSET_BITS-1:0] consumed, consumed_next;
  logic                   seen, seen_next;

  logic                   emit;
  logic [VALUE_BITS-1:0]  mac;
  logic [OFFSET_BITS-1:0] consumed_inc;
  logic [VALUE_BITS-1:0]  final_value;
  logic [itp_pkg::M_TDATA_W-1:0] result_data;
  logic                   is_digit;

  // next item can be taken when the result register is free or draining
  assign q_pop    = q_valid && (!m_tvalid || m_tready);
  assign is_digit = (q_item.kind == itp_pkg::KIND_DIGIT);

  assign mac = acc * VALUE_BITS'(radix) + VALUE_BITS'(q_item.digit);
  assign consumed_inc = (consumed == '1) ? consumed : consumed + 1'b1;
  assign final_value  = negative ? (~acc + 1'b1) : acc;

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    acc_next      = acc;
    consumed_next = consumed;
    seen_next     = seen;
    emit          = 1'b0;
    if (q_item.start) begin
      negative_next = 1'b0;
      acc_next      = '0;
      consumed_next = '0;
      seen_next     = 1'b0;
      case (q_item.kind)
        itp_pkg::KIND_PLUS, itp_pkg::KIND_MINUS: begin
          negative_next = (q_item.kind == itp_pkg::KIND_MINUS);
          consumed_next = OFFSET_BITS'(1);
          phase_next    = PH_SIGNED;
        end
        itp_pkg::KIND_DIGIT: begin
          acc_next      = VALUE_BITS'(q_item.digit);
          consumed_next = OFFSET_BITS'(1);
          seen_next     = 1'b1;
          phase_next    = PH_DIGITS;
        end
        default: begin
          // nothing parsed, reported as no digits
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end
      endcase
    end else if (phase != PH_IDLE) begin
      if (is_digit) begin
        acc_next      = mac;
        consumed_next = consumed_inc;
        seen_next     = 1'b1;
        phase_next    = PH_DIGITS;
      end else begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
      end
    end
  end

  always_comb begin
    if (q_item.start || !seen) begin
      result_data = '0;
    end else begin
      result_data = {itp_pkg::OFFSET_W'(consumed), itp_pkg::VALUE_W'(final_value)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      negative <= 1'b0;
      acc      <= '0;
      consumed <= '0;
      seen     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        phase    <= phase_next;
        negative <= negative_next;
        acc      <= acc_next;
        consumed <= consumed_next;
        seen     <= seen_next;
      end
      if (q_pop && emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= result_data;
        m_tuser  <= q_item.start || !seen;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ design/integer_text_parser.sv @@
// top level of the integer text parser
`timescale 1ns / 1ps

// Parses an integer from a byte stream in a configurable base (2 to 36), one byte per
// cycle sustained while the result side takes results. A byte with s_tuser high starts
// a new string; an optional sign may lead, then digits and letters below the base; the
// first other byte ends the number and produces one result: m_tdata holds the value
// (two's complement when a minus was seen in signed mode) and the count of bytes
// consumed, m_tuser flags a string with no digits. An accepted byte is written into the
// queue and taken from its head by the back end, whose combinational multiply-add of
// the accumulator by the radix updates the parse state; the result is registered when
// the ending byte is taken from the queue. Bytes outside a string are dropped. Write the
// configuration registers only while no string is open.
module integer_text_parser #(
  parameter int VALUE_BITS  = itp_pkg::VALUE_BITS_DEF,
  parameter int OFFSET_BITS = itp_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [itp_pkg::CH_W-1:0]       s_tdata,   // [7:0] ch
  input  logic                           s_tuser,   // [0] start_req
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [itp_pkg::M_TDATA_W-1:0]  m_tdata,   // [63:0] value, [79:64] end_offset
  output logic                           m_tuser,   // [0] no_digits
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [itp_pkg::RADIX_W-1:0]    cfg_wdata
);

  logic [itp_pkg::RADIX_W-1:0] radix;
  logic                        signed_mode;

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  itp_pkg::item_t q_in;
  itp_pkg::item_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= itp_pkg::RADIX_RESET;
      signed_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      case (itp_pkg::cfg_index_t'(cfg_index))
        itp_pkg::CFG_RADIX: begin
          if (cfg_wdata < itp_pkg::RADIX_MIN) begin
            radix <= itp_pkg::RADIX_MIN;
          end else if (cfg_wdata > itp_pkg::RADIX_MAX) begin
            radix <= itp_pkg::RADIX_MAX;
          end else begin
            radix <= cfg_wdata;
          end
        end
        itp_pkg::CFG_SIGNED_MODE: begin
          signed_mode <= cfg_wdata[0];
        end
        default: begin
          radix <= radix;
        end
      endcase
    end
  end

  itp_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .radix       (radix),
    .signed_mode (signed_mode),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  itp_queue #(
    .DEPTH (itp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  itp_back #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .radix    (radix),
    .q_valid  (q_not_empty),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ design/itp_checker.sv @@
// port-level checks for the integer text parser, bound to the top level
`timescale 1ns / 1ps

module itp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [itp_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           m_tuser
);

  // a stalled result keeps its request up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a string with no digits reports zero value and zero count
  a_nodigit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("no-digit result carries data");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // no result in the first cycle after reset
  a_no_early: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result right after reset");

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);

@@ bench/itp_result_checker.sv @@
// result checker for the integer text parser: mirrors the parse of every request and compares
`timescale 1ns / 1ps

module itp_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [itp_pkg::CH_W-1:0]      s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [itp_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          m_tuser,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [itp_pkg::RADIX_W-1:0]   cfg_wdata,
  output int                            fail_count,
  output int                            pending
);

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_SIGN,
    SCAN_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [itp_pkg::VALUE_W-1:0]  value;
    logic [itp_pkg::OFFSET_W-1:0] end_offset;
    logic                         no_digits;
  } number_t;

  number_t                      expected_numbers[$];
  scan_phase_t                  phase;
  logic                         negative;
  logic                         have_digit;
  logic                         mode_signed;
  logic [itp_pkg::VALUE_W-1:0]  acc;
  logic [itp_pkg::OFFSET_W-1:0] consumed;
  logic [itp_pkg::RADIX_W-1:0]  base;

  function automatic int digit_value(input logic [itp_pkg::CH_W-1:0] c,
                                     input logic [itp_pkg::RADIX_W-1:0] rdx);
    int d;
    if (c >= itp_pkg::CH_ZERO && c <= itp_pkg::CH_NINE) begin
      d = int'(c) - int'(itp_pkg::CH_ZERO);
    end else if (c >= itp_pkg::CH_LOWER_A && c <= itp_pkg::CH_LOWER_Z) begin
      d = int'(c) - int'(itp_pkg::CH_LOWER_A) + int'(itp_pkg::LETTER_BASE);
    end else if (c >= itp_pkg::CH_UPPER_A && c <= itp_pkg::CH_UPPER_Z) begin
      d = int'(c) - int'(itp_pkg::CH_UPPER_A) + int'(itp_pkg::LETTER_BASE);
    end else begin
      return -1;
    end
    return (d < int'(rdx)) ? d : -1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic take_byte(input logic [itp_pkg::CH_W-1:0] c, input logic start);
    int d;
    number_t r;
    if (start) begin
      negative   = 1'b0;
      acc        = '0;
      consumed   = '0;
      have_digit = 1'b0;
      if (c == itp_pkg::CH_PLUS || (c == itp_pkg::CH_MINUS && mode_signed)) begin
        negative = (c == itp_pkg::CH_MINUS);
        if (consumed != '1) consumed++;
        phase = SCAN_SIGN;
        return;
      end
    end else if (phase == SCAN_IDLE) begin
      return;
    end
    d = digit_value(c, base);
    if (d < 0) begin
      // number ends here, one result either way
      r.no_digits  = !have_digit;
      r.value      = have_digit ? (negative ? -acc : acc) : '0;
      r.end_offset = have_digit ? consumed : '0;
      expected_numbers.push_back(r);
      phase = SCAN_IDLE;
    end else begin
      acc        = acc * itp_pkg::VALUE_W'(base) + itp_pkg::VALUE_W'(d);
      have_digit = 1'b1;
      if (consumed != '1) consumed++;
      phase = SCAN_DIGITS;
    end
  endtask

  always @(posedge clk) begin
    number_t want;
    if (rst) begin
      phase       = SCAN_IDLE;
      negative    = 1'b0;
      have_digit  = 1'b0;
      acc         = '0;
      consumed    = '0;
      base        = itp_pkg::RADIX_RESET;
      mode_signed = 1'b1;
      fail_count  = 0;
      expected_numbers.delete();
    end else begin
      if (cfg_wr_en) begin
        case (itp_pkg::cfg_index_t'(cfg_index))
          itp_pkg::CFG_RADIX: begin
            base = (cfg_wdata < itp_pkg::RADIX_MIN) ? itp_pkg::RADIX_MIN :
                   (cfg_wdata > itp_pkg::RADIX_MAX) ? itp_pkg::RADIX_MAX : cfg_wdata;
          end
          itp_pkg::CFG_SIGNED_MODE: begin
            mode_signed = cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready)
        take_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (expected_numbers.size() == 0) begin
          report_mismatch("result with no request pending",
                          m_tdata[itp_pkg::VALUE_W-1:0], '0);
        end else begin
          want = expected_numbers.pop_front();
          if (m_tdata[itp_pkg::VALUE_W-1:0] !== want.value)
            report_mismatch("value", m_tdata[itp_pkg::VALUE_W-1:0], want.value);
          if (m_tdata[itp_pkg::M_TDATA_W-1:itp_pkg::VALUE_W] !== want.end_offset)
            report_mismatch("end_offset",
                            64'(m_tdata[itp_pkg::M_TDATA_W-1:itp_pkg::VALUE_W]),
                            64'(want.end_offset));
          if (m_tuser !== want.no_digits)
            report_mismatch("no_digits", 64'(m_tuser), 64'(want.no_digits));
        end
      end
    end
    pending <= expected_numbers.size();
  end

endmodule

@@ bench/tb_integer_text_parser.sv @@
// testbench top for the integer text parser: stimulus, clocking and verdict
`timescale 1ns / 1ps

module tb_integer_text_parser;

  localparam int ITEM_TARGET = 1050;
  localparam int NUM_CFG     = 10;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic [itp_pkg::CH_W-1:0]      s_tdata   = '0;
  logic                          s_tuser   = 1'b0;
  logic                          m_tready  = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic                          cfg_index = itp_pkg::CFG_RADIX;
  logic [itp_pkg::RADIX_W-1:0]   cfg_wdata = '0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic [itp_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          m_tuser;
  int                            fail_count;
  int                            pending;

  bit calm      = 1'b0;
  bit hold_sink = 1'b0;
  int items_sent = 0;
  int digit_span = 10;

  logic [itp_pkg::CH_W-1:0]    stop_chars [8] = '{8'h20, 8'h2c, 8'h2e, 8'h0a, 8'h00, 8'hff,
                                                  itp_pkg::CH_PLUS, itp_pkg::CH_MINUS};
  logic [itp_pkg::RADIX_W-1:0] cfg_radix_tbl [NUM_CFG] = '{6'd36, 6'd16, 6'd8, 6'd63, 6'd1,
                                                           6'd10, 6'd37, 6'd3, 6'd20, 6'd2};
  logic                        cfg_sign_tbl [NUM_CFG] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                                          1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  always #5 clk = ~clk;

  integer_text_parser dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  itp_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        hold_sink = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("integer_text_parser: mismatch");
    $finish;
  end

  function automatic logic [itp_pkg::CH_W-1:0] digit_char(input int d);
    if (d < 10)
      return itp_pkg::CH_W'(itp_pkg::CH_ZERO + d);
    return itp_pkg::CH_W'(($urandom_range(1) ? itp_pkg::CH_UPPER_A : itp_pkg::CH_LOWER_A)
                          + d - 10);
  endfunction

  function automatic logic [itp_pkg::CH_W-1:0] end_char();
    if ($urandom_range(1))
      return itp_pkg::CH_W'($urandom_range(255));
    return stop_chars[$urandom_range(7)];
  endfunction

  task automatic push_byte(input logic [itp_pkg::CH_W-1:0] c, input logic start);
    while (!calm && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // optional sign, len digits (now and then one out of range), then maybe an ending byte
  task automatic push_number(input int len, input bit finish_it);
    logic first;
    int   r;
    int   d;
    first = 1'b1;
    r = $urandom_range(9);
    if (r < 3) begin
      push_byte((r == 0) ? itp_pkg::CH_PLUS : itp_pkg::CH_MINUS, 1'b1);
      first = 1'b0;
    end
    for (int i = 0; i < len; i++) begin
      d = ($urandom_range(15) == 0) ? $urandom_range(35) : $urandom_range(digit_span - 1);
      push_byte(digit_char(d), first);
      first = 1'b0;
    end
    if (finish_it) begin
      push_byte(end_char(), first);
    end
  endtask

  // close any open string, then wait until every result is out
  task automatic close_and_settle();
    push_byte(8'h20, 1'b1);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [itp_pkg::RADIX_W-1:0] rdx, input logic sgn);
    cfg_wr_en <= 1'b1;
    cfg_index <= itp_pkg::CFG_RADIX;
    cfg_wdata <= rdx;
    @(posedge clk);
    cfg_index <= itp_pkg::CFG_SIGNED_MODE;
    cfg_wdata <= {{(itp_pkg::RADIX_W-1){1'b0}}, sgn};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    digit_span = int'((rdx < itp_pkg::RADIX_MIN) ? itp_pkg::RADIX_MIN :
                      (rdx > itp_pkg::RADIX_MAX) ? itp_pkg::RADIX_MAX : rdx);
  endtask

  initial begin
    int p;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: base 10, signed
    push_byte("q", 1'b0);          // stray byte while idle
    push_byte(itp_pkg::CH_MINUS, 1'b1);
    push_byte("1", 1'b0);
    push_byte("2", 1'b0);
    push_byte("3", 1'b0);
    push_byte(" ", 1'b0);
    push_byte(itp_pkg::CH_PLUS, 1'b1);
    push_byte("9", 1'b0);
    push_byte("z", 1'b0);          // letter above the base ends it
    push_byte(itp_pkg::CH_PLUS, 1'b1);
    push_byte(itp_pkg::CH_MINUS, 1'b0);     // sign then no digit
    push_byte(8'hff, 1'b1);
    push_byte("0", 1'b1);
    push_byte("7", 1'b1);          // restart drops the open string
    push_byte(8'h00, 1'b0);
    close_and_settle();

    // widest base, unsigned: minus is not a sign
    set_config(itp_pkg::RADIX_MAX, 1'b0);
    push_byte(itp_pkg::CH_MINUS, 1'b1);
    push_byte("Z", 1'b1);
    push_byte("z", 1'b0);
    push_byte("{", 1'b0);
    close_and_settle();

    // base below range clamps to binary
    set_config(6'd0, 1'b1);
    push_byte(itp_pkg::CH_MINUS, 1'b1);
    push_byte("1", 1'b0);
    push_byte("0", 1'b0);
    push_byte("2", 1'b0);
    close_and_settle();

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      if (p < NUM_CFG)
        set_config(cfg_radix_tbl[p], cfg_sign_tbl[p]);
      else
        set_config(itp_pkg::RADIX_W'($urandom_range(63)), 1'($urandom_range(1)));
      calm = (p == 3);
      if (p == 2)
        hold_sink = 1'b1;
      repeat (20) begin
        case ($urandom_range(9))
          0: push_byte(itp_pkg::CH_W'($urandom_range(255)), 1'b0);
          1: push_number(0, 1'b1);
          2: push_number($urandom_range(20, 40), 1'b1);
          3: push_number($urandom_range(1, 6), 1'b0);
          4: push_byte(itp_pkg::CH_W'($urandom_range(255)), 1'b1);
          default: push_number($urandom_range(1, 12), 1'b1);
        endcase
      end
      close_and_settle();
      p++;
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("integer_text_parser: match");
    else
      $display("integer_text_parser: mismatch");
    $finish;
  end

endmodule
